// ===== src/pwsd_pkg.sv =====
// Shared types and constants for the PID controller with settling detection.
// Command and status structs join the sequencer to the datapath.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package pwsd_pkg;

    // Field widths of the ports and registers
    localparam int ERR_W      = 16;
    localparam int GAIN_W     = 24;
    localparam int DT_W       = 16;
    localparam int DRV_W      = 16;
    localparam int BAND_W     = 15;
    localparam int MARGIN_W   = 16;
    localparam int CNT_W      = 16;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 24;
    localparam int M_TDATA_W  = 24;
    localparam int OUT_PAD_W  = M_TDATA_W - DRV_W - 1;

    // Shared multiplier: 25-bit signed by 17-bit signed
    localparam int MUL_A_W = GAIN_W + 1;
    localparam int MUL_B_W = ERR_W + 1;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;
    localparam int CHUNK_W = 16;

    // Serial divider for the derivative quotient
    localparam int DIV_W = 16;
    localparam int QUO_W = DIV_W + 1;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PROP_GAIN     = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INTEG_GAIN    = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DERIV_GAIN    = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_PERIOD = 4'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DRIVE_LOW     = 4'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_DRIVE_HIGH    = 4'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_ERROR_BAND    = 4'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SETTLE_MARGIN = 4'd7;

    // Register reset values
    localparam logic signed [GAIN_W-1:0] PROP_GAIN_RST     = 24'sd4096;
    localparam logic signed [GAIN_W-1:0] INTEG_GAIN_RST    = 24'sd0;
    localparam logic signed [GAIN_W-1:0] DERIV_GAIN_RST    = 24'sd0;
    localparam logic [DT_W-1:0]          SAMPLE_PERIOD_RST = 16'd500;
    localparam logic signed [DRV_W-1:0]  DRIVE_LOW_RST     = 16'sh8000;
    localparam logic signed [DRV_W-1:0]  DRIVE_HIGH_RST    = 16'sh7FFF;
    localparam logic [BAND_W-1:0]        ERROR_BAND_RST    = 15'd0;
    localparam logic [MARGIN_W-1:0]      SETTLE_MARGIN_RST = 16'd10;

    // Input operation codes
    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_CLEAR  = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOAD,
        ST_INTEG,
        ST_IMUL,
        ST_IACC,
        ST_PMUL,
        ST_PACC,
        ST_DWAIT,
        ST_DMUL,
        ST_DACC,
        ST_CLAMP,
        ST_CLR,
        ST_OUT
    } state_t;

    typedef enum logic [2:0] {
        MUL_NONE,
        MUL_DT_E,
        MUL_KI_CH,
        MUL_KP_E,
        MUL_KD_Q
    } mul_sel_t;

    typedef enum logic [1:0] {
        ACC_HOLD,
        ACC_CLEAR,
        ACC_SHIFT_ADD,
        ACC_ADD
    } acc_op_t;

    typedef struct packed {
        logic     capture;    // latch the input beat
        logic     load;       // start divider, update settle count and last error
        logic     integ_upd;  // saturating integral update
        mul_sel_t mul_sel;
        acc_op_t  acc_op;
        logic     clamp;      // scale, clamp and hold the drive
        logic     clear;      // clear the loop state
        logic     load_out;   // move the result into the output register
    } cmd_t;

    typedef struct packed {
        logic div_done;
        logic out_free;
    } sts_t;

endpackage

`default_nettype wire

// ===== src/pid_with_settling_detect.sv =====
// Top level of the PID controller with output clamp and settling detection.
// Instantiates pwsd_ctrl and pwsd_dp; depends on pwsd_pkg.
//
//  Channel   Direction  Handshake           Payload
//  s_        in         s_tvalid/s_tready   s_tdata: error_in; s_tuser: operation
//  m_        out        m_tvalid/m_tready   m_tdata: drive, steady
//  cfg_      in         cfg_valid/cfg_ready cfg_index: register, cfg_data: value
//
// A control sample runs the 16-step serial divider for the derivative
// alongside the integral and proportional terms; the integral product is
// formed one 16-bit chunk at a time on the shared multiplier. One beat is
// worked on at a time; a finished result waits in the output register
// while the next beat is taken.
// Reset (aresetn low, synchronous) restores register defaults and zeroes the
// loop state. cfg_ready is always high.
`timescale 1ns / 1ps
`default_nettype none

module pid_with_settling_detect #(
    parameter int GAIN_FRAC_BITS = 12,
    parameter int INTEG_WIDTH    = 48
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    input  wire logic [pwsd_pkg::ERR_W-1:0]          s_tdata,   // [15:0] error_in
    input  wire logic                                s_tuser,   // [0] operation
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    output logic [pwsd_pkg::M_TDATA_W-1:0]           m_tdata,   // [15:0] drive, [16] steady
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [pwsd_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [pwsd_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int NCH    = (INTEG_WIDTH + pwsd_pkg::CHUNK_W - 1) / pwsd_pkg::CHUNK_W;
    localparam int CIDX_W = (NCH > 1) ? $clog2(NCH) : 1;

    pwsd_pkg::cmd_t            cmd;
    pwsd_pkg::sts_t            sts;
    logic [CIDX_W-1:0]         chunk_idx;
    logic [pwsd_pkg::DRV_W-1:0] drive;
    logic                      steady;

    pwsd_ctrl #(
        .NCH (NCH)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_op     (s_tuser),
        .in_ready  (s_tready),
        .sts       (sts),
        .cmd       (cmd),
        .chunk_idx (chunk_idx)
    );

    pwsd_dp #(
        .GAIN_FRAC_BITS (GAIN_FRAC_BITS),
        .INTEG_WIDTH    (INTEG_WIDTH),
        .NCH            (NCH)
    ) u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .chunk_idx  (chunk_idx),
        .sts        (sts),
        .in_error   (s_tdata),
        .cfg_we     (cfg_valid),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_drive  (drive),
        .out_steady (steady)
    );

    // Result beat packing
    assign m_tdata   = {{pwsd_pkg::OUT_PAD_W{1'b0}}, steady, drive};
    assign cfg_ready = 1'b1;

endmodule

`default_nettype wire

// ===== src/pwsd_div.sv =====
// Restoring divider, one quotient bit per cycle, for the derivative term.
// Signed result from an unsigned magnitude and a sign; zero divisor gives 0.
// Depends on pwsd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pwsd_div (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              start,
    input  wire logic [pwsd_pkg::DIV_W-1:0]        dividend,
    input  wire logic [pwsd_pkg::DIV_W-1:0]        divisor,
    input  wire logic                              negate,
    output logic                                   done,
    output logic signed [pwsd_pkg::QUO_W-1:0]      quotient
);

    localparam int DW   = pwsd_pkg::DIV_W;
    localparam int STPW = $clog2(DW + 1);

    logic            busy_reg, busy_next;
    logic            done_reg, done_next;
    logic [STPW-1:0] step_reg, step_next;
    logic [DW-1:0]   rem_reg, rem_next;
    logic [DW-1:0]   quo_reg, quo_next;
    logic [DW-1:0]   dvs_reg, dvs_next;
    logic            neg_reg, neg_next;
    logic [DW:0]     shifted;
    logic [DW:0]     trial;

    // One restoring step
    always_comb begin
        shifted   = {rem_reg, quo_reg[DW-1]};
        trial     = shifted - {1'b0, dvs_reg};
        busy_next = busy_reg;
        done_next = done_reg;
        step_next = step_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        neg_next  = neg_reg;
        if (start) begin
            busy_next = 1'b1;
            done_next = 1'b0;
            step_next = STPW'(DW);
            rem_next  = '0;
            quo_next  = dividend;
            dvs_next  = divisor;
            neg_next  = negate;
        end else if (busy_reg) begin
            if (!trial[DW]) begin
                rem_next = trial[DW-1:0];
                quo_next = {quo_reg[DW-2:0], 1'b1};
            end else begin
                rem_next = shifted[DW-1:0];
                quo_next = {quo_reg[DW-2:0], 1'b0};
            end
            step_next = step_reg - 1'b1;
            if (step_reg == STPW'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    // Working registers
    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
        neg_reg <= neg_next;
    end

    // Signed, truncated toward zero
    always_comb begin
        if (dvs_reg == '0) begin
            quotient = '0;
        end else if (neg_reg) begin
            quotient = -$signed({1'b0, quo_reg});
        end else begin
            quotient = $signed({1'b0, quo_reg});
        end
    end

    assign done = done_reg;

endmodule

`default_nettype wire

// ===== src/pwsd_ctrl.sv =====
// Sequencer for the PID datapath: walks one sample through the shared
// multiplier and accumulator. Depends on pwsd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pwsd_ctrl #(
    parameter int NCH = 3
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                in_valid,
    input  wire logic                                in_op,
    output logic                                     in_ready,
    input  wire pwsd_pkg::sts_t                      sts,
    output pwsd_pkg::cmd_t                           cmd,
    output logic [((NCH > 1) ? $clog2(NCH) : 1)-1:0] chunk_idx
);

    localparam int CIDX_W = (NCH > 1) ? $clog2(NCH) : 1;

    pwsd_pkg::state_t  state_reg, state_next;
    logic [CIDX_W-1:0] chunk_reg, chunk_next;

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= pwsd_pkg::ST_IDLE;
            chunk_reg <= '0;
        end else begin
            state_reg <= state_next;
            chunk_reg <= chunk_next;
        end
    end

    // Next state and commands
    always_comb begin
        state_next  = state_reg;
        chunk_next  = chunk_reg;
        in_ready    = 1'b0;
        cmd         = '0;
        cmd.mul_sel = pwsd_pkg::MUL_NONE;
        cmd.acc_op  = pwsd_pkg::ACC_HOLD;
        unique case (state_reg)
            pwsd_pkg::ST_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    cmd.capture = 1'b1;
                    state_next  = (in_op == pwsd_pkg::OP_CLEAR) ? pwsd_pkg::ST_CLR
                                                                : pwsd_pkg::ST_LOAD;
                end
            end
            pwsd_pkg::ST_LOAD: begin
                cmd.load    = 1'b1;
                cmd.mul_sel = pwsd_pkg::MUL_DT_E;
                state_next  = pwsd_pkg::ST_INTEG;
            end
            pwsd_pkg::ST_INTEG: begin
                cmd.integ_upd = 1'b1;
                cmd.acc_op    = pwsd_pkg::ACC_CLEAR;
                chunk_next    = CIDX_W'(NCH - 1);
                state_next    = pwsd_pkg::ST_IMUL;
            end
            pwsd_pkg::ST_IMUL: begin
                cmd.mul_sel = pwsd_pkg::MUL_KI_CH;
                state_next  = pwsd_pkg::ST_IACC;
            end
            pwsd_pkg::ST_IACC: begin
                cmd.acc_op = pwsd_pkg::ACC_SHIFT_ADD;
                if (chunk_reg == '0) begin
                    state_next = pwsd_pkg::ST_PMUL;
                end else begin
                    chunk_next = chunk_reg - 1'b1;
                    state_next = pwsd_pkg::ST_IMUL;
                end
            end
            pwsd_pkg::ST_PMUL: begin
                cmd.mul_sel = pwsd_pkg::MUL_KP_E;
                state_next  = pwsd_pkg::ST_PACC;
            end
            pwsd_pkg::ST_PACC: begin
                cmd.acc_op = pwsd_pkg::ACC_ADD;
                state_next = pwsd_pkg::ST_DWAIT;
            end
            pwsd_pkg::ST_DWAIT: begin
                if (sts.div_done) begin
                    state_next = pwsd_pkg::ST_DMUL;
                end
            end
            pwsd_pkg::ST_DMUL: begin
                cmd.mul_sel = pwsd_pkg::MUL_KD_Q;
                state_next  = pwsd_pkg::ST_DACC;
            end
            pwsd_pkg::ST_DACC: begin
                cmd.acc_op = pwsd_pkg::ACC_ADD;
                state_next = pwsd_pkg::ST_CLAMP;
            end
            pwsd_pkg::ST_CLAMP: begin
                cmd.clamp  = 1'b1;
                state_next = pwsd_pkg::ST_OUT;
            end
            pwsd_pkg::ST_CLR: begin
                cmd.clear  = 1'b1;
                state_next = pwsd_pkg::ST_OUT;
            end
            pwsd_pkg::ST_OUT: begin
                if (sts.out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = pwsd_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = pwsd_pkg::ST_IDLE;
            end
        endcase
    end

    assign chunk_idx = chunk_reg;

`ifndef SYNTH
    // Derivative product must not start before the quotient is ready
    a_deriv_after_div: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == pwsd_pkg::ST_DMUL) |-> sts.div_done)
        else $error("derivative multiply issued before divider finished");

    // Output register is only loaded when it is free
    a_out_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |-> sts.out_free)
        else $error("result loaded over an untaken result");

    // An accepted beat always starts a sample or a clear
    a_accept_start: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid && in_ready) |=>
            (state_reg == pwsd_pkg::ST_LOAD || state_reg == pwsd_pkg::ST_CLR))
        else $error("accepted beat did not start processing");

    // Integral chunks are walked from the top down, one per pass
    a_chunk_walk: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == pwsd_pkg::ST_IACC && chunk_reg != '0) |=>
            (state_reg == pwsd_pkg::ST_IMUL && chunk_reg == $past(chunk_reg) - 1'b1))
        else $error("integral chunk sequence broken");
`endif

endmodule

`default_nettype wire

// ===== src/pwsd_dp.sv =====
// PID datapath: configuration registers, loop state, shared multiplier,
// wide accumulator, clamp and output register. Depends on pwsd_pkg, pwsd_div.
`timescale 1ns / 1ps
`default_nettype none

module pwsd_dp #(
    parameter int GAIN_FRAC_BITS = 12,
    parameter int INTEG_WIDTH    = 48,
    parameter int NCH            = 3
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire pwsd_pkg::cmd_t                      cmd,
    input  wire logic [((NCH > 1) ? $clog2(NCH) : 1)-1:0] chunk_idx,
    output pwsd_pkg::sts_t                           sts,
    input  wire logic [pwsd_pkg::ERR_W-1:0]          in_error,
    input  wire logic                                cfg_we,
    input  wire logic [pwsd_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [pwsd_pkg::CFG_DATA_W-1:0]     cfg_data,
    output logic                                     out_valid,
    input  wire logic                                out_ready,
    output logic [pwsd_pkg::DRV_W-1:0]               out_drive,
    output logic                                     out_steady
);

    localparam int IW    = INTEG_WIDTH;
    localparam int CW    = pwsd_pkg::CHUNK_W;
    localparam int IXW   = NCH * CW;
    localparam int ACC_W = pwsd_pkg::GAIN_W + IXW + 1;
    localparam int EW    = pwsd_pkg::ERR_W;
    localparam int DRW   = pwsd_pkg::DRV_W;
    localparam int AW    = pwsd_pkg::MUL_A_W;
    localparam int BW    = pwsd_pkg::MUL_B_W;

    // Configuration registers
    logic signed [pwsd_pkg::GAIN_W-1:0] kp_reg, ki_reg, kd_reg;
    logic [pwsd_pkg::DT_W-1:0]          period_reg;
    logic signed [DRW-1:0]              low_reg, high_reg;
    logic [pwsd_pkg::BAND_W-1:0]        band_reg;
    logic [pwsd_pkg::MARGIN_W-1:0]      margin_reg;

    // Loop state
    logic signed [IW-1:0]          integ_reg, integ_next;
    logic signed [EW-1:0]          last_err_reg;
    logic [pwsd_pkg::CNT_W-1:0]    cnt_reg, cnt_next;
    logic                          flag_reg, flag_next;
    logic signed [DRW-1:0]         held_reg, held_next;

    // Working registers
    logic signed [EW-1:0]              err_reg;
    logic signed [pwsd_pkg::PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]           acc_reg, acc_next;
    logic                              ovalid_reg;
    logic [DRW-1:0]                    odrive_reg;
    logic                              osteady_reg;

    // Combinational helpers
    logic signed [AW-1:0]         mul_a;
    logic signed [BW-1:0]         mul_b;
    logic signed [IXW-1:0]        integ_x;
    logic [CW-1:0]                chunk;
    logic signed [IW:0]           isum;
    logic signed [IW-1:0]         imax, imin;
    logic signed [EW:0]           diff;
    logic [EW:0]                  diff_mag;
    logic signed [EW:0]           e_x, band_x;
    logic                         in_band;
    logic [pwsd_pkg::CNT_W-1:0]   cnt_inc;
    logic signed [ACC_W-1:0]      scaled, hi_x, lo_x;
    logic                         div_done;
    logic signed [pwsd_pkg::QUO_W-1:0] quo;

    // Configuration writes, indexes past the list are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kp_reg     <= pwsd_pkg::PROP_GAIN_RST;
            ki_reg     <= pwsd_pkg::INTEG_GAIN_RST;
            kd_reg     <= pwsd_pkg::DERIV_GAIN_RST;
            period_reg <= pwsd_pkg::SAMPLE_PERIOD_RST;
            low_reg    <= pwsd_pkg::DRIVE_LOW_RST;
            high_reg   <= pwsd_pkg::DRIVE_HIGH_RST;
            band_reg   <= pwsd_pkg::ERROR_BAND_RST;
            margin_reg <= pwsd_pkg::SETTLE_MARGIN_RST;
        end else if (cfg_we) begin
            unique case (cfg_index)
                pwsd_pkg::CFG_PROP_GAIN:     kp_reg     <= $signed(cfg_data);
                pwsd_pkg::CFG_INTEG_GAIN:    ki_reg     <= $signed(cfg_data);
                pwsd_pkg::CFG_DERIV_GAIN:    kd_reg     <= $signed(cfg_data);
                pwsd_pkg::CFG_SAMPLE_PERIOD: period_reg <= cfg_data[pwsd_pkg::DT_W-1:0];
                pwsd_pkg::CFG_DRIVE_LOW:     low_reg    <= $signed(cfg_data[DRW-1:0]);
                pwsd_pkg::CFG_DRIVE_HIGH:    high_reg   <= $signed(cfg_data[DRW-1:0]);
                pwsd_pkg::CFG_ERROR_BAND:    band_reg   <= cfg_data[pwsd_pkg::BAND_W-1:0];
                pwsd_pkg::CFG_SETTLE_MARGIN: margin_reg <= cfg_data[pwsd_pkg::MARGIN_W-1:0];
                default: ;
            endcase
        end
    end

    // Error difference for the derivative
    always_comb begin
        diff     = (EW+1)'(err_reg) - (EW+1)'(last_err_reg);
        diff_mag = diff[EW] ? (EW+1)'(-diff) : (EW+1)'(diff);
    end

    pwsd_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.load),
        .dividend (diff_mag[pwsd_pkg::DIV_W-1:0]),
        .divisor  (period_reg),
        .negate   (diff[EW]),
        .done     (div_done),
        .quotient (quo)
    );

    // Shared multiplier operand select
    always_comb begin
        integ_x = IXW'(integ_reg);
        chunk   = integ_x[chunk_idx*CW +: CW];
        mul_a   = '0;
        mul_b   = '0;
        unique case (cmd.mul_sel)
            pwsd_pkg::MUL_NONE: begin
                mul_a = '0;
                mul_b = '0;
            end
            pwsd_pkg::MUL_DT_E: begin
                mul_a = $signed(AW'(period_reg));
                mul_b = BW'(err_reg);
            end
            pwsd_pkg::MUL_KI_CH: begin
                mul_a = AW'(ki_reg);
                // top chunk carries the sign, lower chunks are unsigned
                if (chunk_idx == ($bits(chunk_idx))'(NCH - 1)) begin
                    mul_b = BW'($signed(chunk));
                end else begin
                    mul_b = $signed(BW'(chunk));
                end
            end
            pwsd_pkg::MUL_KP_E: begin
                mul_a = AW'(kp_reg);
                mul_b = BW'(err_reg);
            end
            pwsd_pkg::MUL_KD_Q: begin
                mul_a = AW'(kd_reg);
                mul_b = quo;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Accumulator
    always_comb begin
        unique case (cmd.acc_op)
            pwsd_pkg::ACC_HOLD:      acc_next = acc_reg;
            pwsd_pkg::ACC_CLEAR:     acc_next = '0;
            pwsd_pkg::ACC_SHIFT_ADD: acc_next = (acc_reg <<< CW) + ACC_W'(prod_reg);
            pwsd_pkg::ACC_ADD:       acc_next = acc_reg + ACC_W'(prod_reg);
            default:                 acc_next = acc_reg;
        endcase
    end

    // Saturating integral, settle counter, clamp
    always_comb begin
        imax       = $signed({1'b0, {(IW-1){1'b1}}});
        imin       = $signed({1'b1, {(IW-1){1'b0}}});
        isum       = (IW+1)'(integ_reg) + (IW+1)'(prod_reg);
        integ_next = integ_reg;
        if (cmd.clear) begin
            integ_next = '0;
        end else if (cmd.integ_upd) begin
            if (isum[IW] != isum[IW-1]) begin
                integ_next = isum[IW] ? imin : imax;
            end else begin
                integ_next = isum[IW-1:0];
            end
        end

        e_x     = (EW+1)'(err_reg);
        band_x  = $signed({2'b00, band_reg});
        in_band = (e_x > -band_x) && (e_x < band_x);
        cnt_inc = (cnt_reg == '1) ? cnt_reg : cnt_reg + 1'b1;
        cnt_next  = cnt_reg;
        flag_next = flag_reg;
        if (cmd.clear) begin
            cnt_next  = '0;
            flag_next = 1'b0;
        end else if (cmd.load) begin
            if (in_band) begin
                cnt_next = cnt_inc;
                if (cnt_inc > margin_reg) begin
                    flag_next = 1'b1;
                end
            end else begin
                cnt_next = '0;
            end
        end

        scaled    = acc_reg >>> GAIN_FRAC_BITS;
        hi_x      = ACC_W'(high_reg);
        lo_x      = ACC_W'(low_reg);
        held_next = held_reg;
        if (cmd.clamp) begin
            priority if (scaled > hi_x) begin
                held_next = high_reg;
            end else if (scaled < lo_x) begin
                held_next = low_reg;
            end else begin
                held_next = scaled[DRW-1:0];
            end
        end
    end

    // Loop state and output valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            integ_reg    <= '0;
            last_err_reg <= '0;
            cnt_reg      <= '0;
            flag_reg     <= 1'b0;
            held_reg     <= '0;
            ovalid_reg   <= 1'b0;
        end else begin
            integ_reg <= integ_next;
            cnt_reg   <= cnt_next;
            flag_reg  <= flag_next;
            held_reg  <= held_next;
            if (cmd.load) begin
                last_err_reg <= err_reg;
            end
            if (cmd.load_out) begin
                ovalid_reg <= 1'b1;
            end else if (out_ready) begin
                ovalid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            err_reg <= $signed(in_error);
        end
        prod_reg <= mul_a * mul_b;
        acc_reg  <= acc_next;
        if (cmd.load_out) begin
            odrive_reg  <= held_reg;
            osteady_reg <= flag_reg;
        end
    end

    assign sts.div_done = div_done;
    assign sts.out_free = !ovalid_reg || out_ready;
    assign out_valid    = ovalid_reg;
    assign out_drive    = odrive_reg;
    assign out_steady   = osteady_reg;

endmodule

`default_nettype wire
